// ----- hdl/sst_pkg.sv -----
package sst_pkg;

    // Fixed field widths of the beats on both channels
    localparam int SLOT_W = 6;
    localparam int VPN_W  = 20;
    localparam int PID_W  = 8;
    localparam int PHYS_W = 12;

    typedef enum logic [2:0] {
        OP_ALLOC     = 3'd0,
        OP_SEARCH    = 3'd1,
        OP_FREE_SLOT = 3'd2,
        OP_FREE_PID  = 3'd3,
        OP_WRITE     = 3'd4,
        OP_READ      = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [VPN_W-1:0]  vpn;
        logic [PID_W-1:0]  pid;
        logic [PHYS_W-1:0] phys_page;
        logic              valid_in;
        logic              dirty_in;
        logic              use_in;
        logic              read_only_in;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot_out;
        logic [VPN_W-1:0]  vpn_out;
        logic [PID_W-1:0]  pid_out;
        logic [PHYS_W-1:0] phys_page_out;
        logic              valid_out;
        logic              dirty_out;
        logic              use_out;
        logic              read_only_out;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RDATA,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load_req;
        logic scan_init;
        logic exec;
        logic scan_step;
        logic rd_capture;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       clear_last;
        logic       scan_done;
    } dp_sts_t;

endpackage

// ----- hdl/swap_slot_table.sv -----
// Swap slot table: SLOTS entries (virtual page, process id, physical page and
// valid, dirty, use and read-only marks) with an allocation bitmap, driven by
// one command beat on the s_ channel and answered by exactly one result beat
// on the m_ channel. After reset the block runs a clearing pass over every
// slot of both memories with s_ready low. One command is handled at a time:
// write, free slot and the unused codes go from execute to result, read
// adds a read data step, and the scanning commands walk the slots one per
// cycle through the single read port of the entry and bitmap memories;
// allocate and search stop at the first slot that answers, free process
// walks every slot. A new command is accepted while the previous result
// beat still waits on m_.
module swap_slot_table #(
    parameter int SLOTS    = 64,
    parameter int VPN_BITS = 20,
    parameter int PID_BITS = 8
) (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          s_valid,
    output logic          s_ready,
    input  sst_pkg::req_t s_payload,

    output logic          m_valid,
    input  logic          m_ready,
    output sst_pkg::rsp_t m_payload
);

    sst_pkg::dp_cmd_t cmd;
    sst_pkg::dp_sts_t sts;

    // Sequence the command: clear pass, accept, execute or scan, hand off beat
    sst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Hold the memories, scan pointer and result registers
    sst_dp #(
        .SLOTS    (SLOTS),
        .VPN_BITS (VPN_BITS),
        .PID_BITS (PID_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_payload (s_payload),
        .m_payload (m_payload)
    );

endmodule

// ----- hdl/sst_ram.sv -----
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/sst_ctrl.sv -----
module sst_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output sst_pkg::dp_cmd_t cmd,
    input  sst_pkg::dp_sts_t sts
);

    sst_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sst_pkg::ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sst_pkg::ST_CLEAR: begin
                if (sts.clear_last) begin
                    state_next = sst_pkg::ST_IDLE;
                end
            end
            sst_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sst_pkg::ST_EXEC;
                end
            end
            sst_pkg::ST_EXEC: begin
                unique case (sts.op) inside
                    sst_pkg::OP_ALLOC, sst_pkg::OP_SEARCH, sst_pkg::OP_FREE_PID: begin
                        state_next = sst_pkg::ST_SCAN;
                    end
                    sst_pkg::OP_READ: begin
                        state_next = sst_pkg::ST_RDATA;
                    end
                    default: begin
                        state_next = sst_pkg::ST_RESULT;
                    end
                endcase
            end
            sst_pkg::ST_SCAN: begin
                if (sts.scan_done) begin
                    state_next = sst_pkg::ST_RESULT;
                end
            end
            sst_pkg::ST_RDATA: begin
                state_next = sst_pkg::ST_RESULT;
            end
            sst_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = sst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sst_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            sst_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
            end
            sst_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            sst_pkg::ST_EXEC: begin
                unique case (sts.op) inside
                    sst_pkg::OP_ALLOC, sst_pkg::OP_SEARCH, sst_pkg::OP_FREE_PID: begin
                        cmd.scan_init = 1'b1;
                    end
                    default: begin
                        cmd.exec = 1'b1;
                    end
                endcase
            end
            sst_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            sst_pkg::ST_RDATA: begin
                cmd.rd_capture = 1'b1;
            end
            sst_pkg::ST_RESULT: begin
                cmd.out_load = !m_valid_reg || m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Hold the beat until taken; a fresh load overrides the drain
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- hdl/sst_dp.sv -----
module sst_dp #(
    parameter int SLOTS    = 64,
    parameter int VPN_BITS = 20,
    parameter int PID_BITS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  sst_pkg::dp_cmd_t cmd,
    output sst_pkg::dp_sts_t sts,
    input  sst_pkg::req_t    s_payload,
    output sst_pkg::rsp_t    m_payload
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = ((AW > sst_pkg::SLOT_W) ? AW : sst_pkg::SLOT_W) + 1;

    typedef struct packed {
        logic [VPN_BITS-1:0]        vpn;
        logic [PID_BITS-1:0]        pid;
        logic [sst_pkg::PHYS_W-1:0] phys;
        logic                       mark_valid;
        logic                       mark_dirty;
        logic                       mark_use;
        logic                       mark_ro;
    } entry_t;

    localparam int EW = $bits(entry_t);

    sst_pkg::req_t req_reg;
    sst_pkg::rsp_t res_reg, res_next;
    sst_pkg::rsp_t out_reg;

    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] pidx_reg, pidx_next;
    logic          pend_reg, pend_next;

    logic [SW-1:0] slot_w;
    logic          in_range;
    logic [AW-1:0] slot_addr;
    logic          scan_end_idx;

    logic          ent_we, map_we;
    logic [AW-1:0] ent_waddr, map_waddr, raddr;
    entry_t        ent_wdata, ent_rdata;
    logic          map_wdata, map_rdata;

    logic          vpn_eq, pid_eq, hit, at_end;
    logic [2:0]    op;

    assign op        = req_reg.op;
    assign slot_w    = SW'(req_reg.slot);
    assign in_range  = slot_w < SW'(SLOTS);
    assign slot_addr = slot_w[AW-1:0];

    assign scan_end_idx = idx_reg == CW'(SLOTS);

    assign raddr = cmd.scan_step ? idx_reg[AW-1:0] : slot_addr;

    assign vpn_eq = ent_rdata.vpn == VPN_BITS'(req_reg.vpn);
    assign pid_eq = ent_rdata.pid == PID_BITS'(req_reg.pid);

    assign hit = pend_reg &&
                 (((op == sst_pkg::OP_ALLOC) && !map_rdata) ||
                  ((op == sst_pkg::OP_SEARCH) && map_rdata && vpn_eq && pid_eq));
    assign at_end = scan_end_idx && !pend_reg;

    assign sts.op         = op;
    assign sts.clear_last = idx_reg == CW'(SLOTS - 1);
    assign sts.scan_done  = hit || at_end;

    always_comb begin
        ent_wdata            = '0;
        ent_wdata.vpn        = VPN_BITS'(req_reg.vpn);
        ent_wdata.pid        = PID_BITS'(req_reg.pid);
        ent_wdata.phys       = req_reg.phys_page;
        ent_wdata.mark_valid = req_reg.valid_in;
        ent_wdata.mark_dirty = req_reg.dirty_in;
        ent_wdata.mark_use   = req_reg.use_in;
        ent_wdata.mark_ro    = req_reg.read_only_in;
        ent_waddr            = slot_addr;
        ent_we               = cmd.exec && (op == sst_pkg::OP_WRITE) && in_range;
        if (cmd.clear_step) begin
            ent_wdata = '0;
            ent_waddr = idx_reg[AW-1:0];
            ent_we    = 1'b1;
        end
    end

    always_comb begin
        map_we    = 1'b0;
        map_waddr = pidx_reg;
        map_wdata = op == sst_pkg::OP_ALLOC;
        if (cmd.clear_step) begin
            map_we    = 1'b1;
            map_waddr = idx_reg[AW-1:0];
            map_wdata = 1'b0;
        end else if (cmd.exec) begin
            map_we    = (op == sst_pkg::OP_FREE_SLOT) && in_range;
            map_waddr = slot_addr;
            map_wdata = 1'b0;
        end else if (cmd.scan_step) begin
            // Claim on an allocate hit; drop every pid match on free process
            map_we = (hit && (op == sst_pkg::OP_ALLOC)) ||
                     (pend_reg && (op == sst_pkg::OP_FREE_PID) && pid_eq);
        end
    end

    sst_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_entries (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (raddr),
        .rdata (ent_rdata)
    );

    sst_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_alloc_map (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (raddr),
        .rdata (map_rdata)
    );

    always_comb begin
        idx_next  = idx_reg;
        pidx_next = pidx_reg;
        pend_next = pend_reg;
        if (cmd.clear_step) begin
            idx_next = idx_reg + CW'(1);
        end else if (cmd.scan_init) begin
            idx_next  = '0;
            pend_next = 1'b0;
        end else if (cmd.scan_step) begin
            if (!scan_end_idx) begin
                idx_next  = idx_reg + CW'(1);
                pidx_next = idx_reg[AW-1:0];
                pend_next = 1'b1;
            end else begin
                pend_next = 1'b0;
            end
        end
    end

    always_comb begin
        res_next = res_reg;
        if (cmd.exec) begin
            res_next = '0;
        end else if (cmd.scan_step && sts.scan_done) begin
            res_next = '0;
            if (hit) begin
                res_next.found    = 1'b1;
                res_next.slot_out = sst_pkg::SLOT_W'(pidx_reg);
            end
        end else if (cmd.rd_capture) begin
            res_next          = '0;
            res_next.slot_out = req_reg.slot;
            if (in_range) begin
                res_next.vpn_out       = sst_pkg::VPN_W'(ent_rdata.vpn);
                res_next.pid_out       = sst_pkg::PID_W'(ent_rdata.pid);
                res_next.phys_page_out = ent_rdata.phys;
                res_next.valid_out     = ent_rdata.mark_valid;
                res_next.dirty_out     = ent_rdata.mark_dirty;
                res_next.use_out       = ent_rdata.mark_use;
                res_next.read_only_out = ent_rdata.mark_ro;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg <= pidx_next;
        res_reg  <= res_next;
        if (cmd.load_req) begin
            req_reg <= s_payload;
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign m_payload = out_reg;

endmodule

// ----- dv/tb_swap_slot_table.sv -----
`timescale 1ns / 1ps

module tb_swap_slot_table;

    localparam int N_SLOTS        = 64;
    localparam int HOLD_AT_BEAT   = 600;   // result beat at which the long hold-off starts
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either side
    localparam int MAX_REPORTS    = 10;
    localparam int BLOCK_CMDS     = 230;
    localparam int N_BLOCKS       = 8;

    // Op codes the package leaves unnamed; the block must treat them as no-ops
    localparam logic [2:0] OP_UNUSED6 = 3'd6;
    localparam logic [2:0] OP_UNUSED7 = 3'd7;

    // Shadow copy of one slot as the block should hold it
    typedef struct packed {
        logic [sst_pkg::VPN_W-1:0]  vpn;
        logic [sst_pkg::PID_W-1:0]  pid;
        logic [sst_pkg::PHYS_W-1:0] phys;
        logic                       valid;
        logic                       dirty;
        logic                       used_mark;
        logic                       ro;
    } slot_rec_t;

    // One row of the directed table: a command and, where it is obvious, the answer
    typedef struct {
        sst_pkg::req_t beat;
        bit            fixed;
        sst_pkg::rsp_t want;
    } step_row_t;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    logic          s_ready;
    sst_pkg::req_t s_payload = '0;
    logic          m_valid;
    logic          m_ready   = 1'b0;
    sst_pkg::rsp_t m_payload;

    // Predicted table state
    bit        shadow_map [N_SLOTS];
    slot_rec_t shadow_ent [N_SLOTS];
    int        last_grant;
    bit        last_grant_ok;

    sst_pkg::rsp_t awaited_rsp [$];
    step_row_t     directed_steps [$];

    logic [sst_pkg::VPN_W-1:0] vpn_pool [8];
    logic [sst_pkg::PID_W-1:0] pid_pool [4];

    bit tx_busy = 1'b1;
    bit rx_busy = 1'b1;

    int cmds_sent     = 0;
    int beats_taken   = 0;
    int errors        = 0;
    int full_refusals = 0;
    int search_hits   = 0;
    int stuck_cycles  = 0;
    int ops_seen [8];

    always #5 aclk = ~aclk;

    swap_slot_table #(
        .SLOTS   (N_SLOTS),
        .VPN_BITS(sst_pkg::VPN_W),
        .PID_BITS(sst_pkg::PID_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    // ------------------------------------------------------------------
    // Predictor: apply one accepted command to the shadow table and
    // return the result beat it must produce.
    // ------------------------------------------------------------------
    function automatic sst_pkg::rsp_t apply_cmd(sst_pkg::req_t c);
        sst_pkg::rsp_t r;
        bit            hit;
        r   = '0;
        hit = 1'b0;
        case (c.op)
            sst_pkg::OP_ALLOC: begin
                // lowest free slot wins; a full table changes nothing
                last_grant_ok = 1'b0;
                for (int i = 0; i < N_SLOTS && !hit; i++) begin
                    if (!shadow_map[i]) begin
                        shadow_map[i] = 1'b1;
                        r.found       = 1'b1;
                        r.slot_out    = sst_pkg::SLOT_W'(i);
                        last_grant    = i;
                        last_grant_ok = 1'b1;
                        hit           = 1'b1;
                    end
                end
            end
            sst_pkg::OP_SEARCH: begin
                // only allocated slots take part, lowest index first
                for (int i = 0; i < N_SLOTS && !hit; i++) begin
                    if (shadow_map[i] && shadow_ent[i].vpn == c.vpn &&
                            shadow_ent[i].pid == c.pid) begin
                        r.found    = 1'b1;
                        r.slot_out = sst_pkg::SLOT_W'(i);
                        hit        = 1'b1;
                    end
                end
            end
            sst_pkg::OP_FREE_SLOT: begin
                if (c.slot < N_SLOTS)
                    shadow_map[c.slot] = 1'b0;
            end
            sst_pkg::OP_FREE_PID: begin
                // drop the allocation bit on every matching slot, allocated or not
                for (int i = 0; i < N_SLOTS; i++)
                    if (shadow_ent[i].pid == c.pid)
                        shadow_map[i] = 1'b0;
            end
            sst_pkg::OP_WRITE: begin
                // contents only; the allocation bitmap is left alone
                if (c.slot < N_SLOTS)
                    shadow_ent[c.slot] = '{vpn: c.vpn, pid: c.pid, phys: c.phys_page,
                                           valid: c.valid_in, dirty: c.dirty_in,
                                           used_mark: c.use_in, ro: c.read_only_in};
            end
            sst_pkg::OP_READ: begin
                r.slot_out = c.slot;
                if (c.slot < N_SLOTS) begin
                    r.vpn_out       = shadow_ent[c.slot].vpn;
                    r.pid_out       = shadow_ent[c.slot].pid;
                    r.phys_page_out = shadow_ent[c.slot].phys;
                    r.valid_out     = shadow_ent[c.slot].valid;
                    r.dirty_out     = shadow_ent[c.slot].dirty;
                    r.use_out       = shadow_ent[c.slot].used_mark;
                    r.read_only_out = shadow_ent[c.slot].ro;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int idle_gap(bit busy);
        return busy ? $urandom_range(0, 18) : 0;
    endfunction

    function automatic sst_pkg::req_t cmd(logic [2:0] op, int slot, int vpn, int pid,
                                          int phys, logic [3:0] marks);
        sst_pkg::req_t c;
        c.op        = op;
        c.slot      = sst_pkg::SLOT_W'(slot);
        c.vpn       = sst_pkg::VPN_W'(vpn);
        c.pid       = sst_pkg::PID_W'(pid);
        c.phys_page = sst_pkg::PHYS_W'(phys);
        {c.valid_in, c.dirty_in, c.use_in, c.read_only_in} = marks;
        return c;
    endfunction

    function automatic sst_pkg::rsp_t result_of(bit found, int slot, int vpn, int pid,
                                                int phys, logic [3:0] marks);
        sst_pkg::rsp_t r;
        r.found         = found;
        r.slot_out      = sst_pkg::SLOT_W'(slot);
        r.vpn_out       = sst_pkg::VPN_W'(vpn);
        r.pid_out       = sst_pkg::PID_W'(pid);
        r.phys_page_out = sst_pkg::PHYS_W'(phys);
        {r.valid_out, r.dirty_out, r.use_out, r.read_only_out} = marks;
        return r;
    endfunction

    function automatic void add_row(sst_pkg::req_t c, bit fixed, sst_pkg::rsp_t want);
        step_row_t row;
        row.beat  = c;
        row.fixed = fixed;
        row.want  = want;
        directed_steps.push_back(row);
    endfunction

    // Keys mostly come from small pools so that searches hit and process
    // frees match; now and then a full-range draw exercises every bit.
    function automatic logic [sst_pkg::VPN_W-1:0] pick_vpn();
        if ($urandom_range(0, 7) == 0)
            return sst_pkg::VPN_W'($urandom_range(0, (1 << sst_pkg::VPN_W) - 1));
        return vpn_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [sst_pkg::PID_W-1:0] pick_pid();
        if ($urandom_range(0, 7) == 0)
            return sst_pkg::PID_W'($urandom_range(0, (1 << sst_pkg::PID_W) - 1));
        return pid_pool[$urandom_range(0, 3)];
    endfunction

    function automatic sst_pkg::req_t make_cmd();
        sst_pkg::req_t c;
        int            roll;
        int            k;
        c.slot      = sst_pkg::SLOT_W'(($urandom_range(0, 3) == 0)
                                       ? $urandom_range(0, N_SLOTS - 1)
                                       : $urandom_range(0, 15));
        c.vpn       = pick_vpn();
        c.pid       = pick_pid();
        c.phys_page = sst_pkg::PHYS_W'($urandom_range(0, (1 << sst_pkg::PHYS_W) - 1));
        {c.valid_in, c.dirty_in, c.use_in, c.read_only_in} = 4'($urandom_range(0, 15));
        roll = $urandom_range(0, 99);
        if (roll < 25)
            c.op = sst_pkg::OP_ALLOC;
        else if (roll < 45)
            c.op = sst_pkg::OP_WRITE;
        else if (roll < 65) begin
            c.op = sst_pkg::OP_SEARCH;
            // aim most searches at a key that is really stored somewhere
            if ($urandom_range(0, 4) < 3) begin
                k     = $urandom_range(0, 15);
                c.vpn = shadow_ent[k].vpn;
                c.pid = shadow_ent[k].pid;
            end
        end else if (roll < 80)
            c.op = sst_pkg::OP_READ;
        else if (roll < 90)
            c.op = sst_pkg::OP_FREE_SLOT;
        else if (roll < 95)
            c.op = sst_pkg::OP_FREE_PID;
        else
            c.op = $urandom_range(0, 1) ? OP_UNUSED6 : OP_UNUSED7;
        return c;
    endfunction

    // Offer one command beat after a drawn gap; predict once it is taken.
    // Valid is only lowered when a gap follows, so it never drops and rises
    // within one time step.
    task automatic offer(sst_pkg::req_t c, bit fixed, sst_pkg::rsp_t want);
        sst_pkg::rsp_t pred;
        int            gap;
        gap = idle_gap(tx_busy);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_payload <= c;
        do @(posedge aclk); while (!s_ready);
        pred = apply_cmd(c);
        ops_seen[c.op]++;
        cmds_sent++;
        if (c.op == sst_pkg::OP_ALLOC && !pred.found)
            full_refusals++;
        if (c.op == sst_pkg::OP_SEARCH && pred.found)
            search_hits++;
        awaited_rsp.push_back(fixed ? want : pred);
    endtask

    // Hold the sender off until every outstanding result has come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge aclk);
    endtask

    // A well-formed slot lifetime: grab a slot, fill it, look it up, read it
    // back and sometimes let it go again.
    task automatic run_lifecycle();
        sst_pkg::req_t c;
        int            k;
        c    = make_cmd();
        c.op = sst_pkg::OP_ALLOC;
        offer(c, 1'b0, '0);
        k      = last_grant_ok ? last_grant : $urandom_range(0, N_SLOTS - 1);
        c      = make_cmd();
        c.op   = sst_pkg::OP_WRITE;
        c.slot = sst_pkg::SLOT_W'(k);
        offer(c, 1'b0, '0);
        c.op = sst_pkg::OP_SEARCH;
        offer(c, 1'b0, '0);
        c.op = sst_pkg::OP_READ;
        offer(c, 1'b0, '0);
        if ($urandom_range(0, 3) == 0) begin
            c.op = $urandom_range(0, 1) ? sst_pkg::OP_FREE_SLOT : sst_pkg::OP_FREE_PID;
            offer(c, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: take beats with drawn gaps, hold off once for a long
    // stretch so the block backs up, and check every beat in order.
    // ------------------------------------------------------------------
    initial begin
        int            gap;
        sst_pkg::rsp_t exp_r;
        sst_pkg::rsp_t got;
        bit            bad;
        wait (aresetn === 1'b1);
        forever begin
            if (beats_taken % 50 == 0)
                rx_busy = ($urandom_range(0, 2) != 0);
            gap = (beats_taken == HOLD_AT_BEAT) ? HOLD_CYCLES : idle_gap(rx_busy);
            if (gap > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = m_payload;
            beats_taken++;
            if (awaited_rsp.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("Result beat %0d arrived with nothing outstanding",
                             beats_taken);
            end else begin
                exp_r = awaited_rsp.pop_front();
                bad = (got.found !== exp_r.found) || (got.slot_out !== exp_r.slot_out) ||
                      (got.vpn_out !== exp_r.vpn_out) || (got.pid_out !== exp_r.pid_out) ||
                      (got.phys_page_out !== exp_r.phys_page_out) ||
                      (got.valid_out !== exp_r.valid_out) ||
                      (got.dirty_out !== exp_r.dirty_out) ||
                      (got.use_out !== exp_r.use_out) ||
                      (got.read_only_out !== exp_r.read_only_out);
                if (bad) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("Mismatch on result beat %0d", beats_taken);
                        $display({"  expected found=%0b slot=%0d vpn=%05h pid=%02h",
                                  " phys=%03h vdur=%b%b%b%b"},
                                 exp_r.found, exp_r.slot_out, exp_r.vpn_out, exp_r.pid_out,
                                 exp_r.phys_page_out, exp_r.valid_out, exp_r.dirty_out,
                                 exp_r.use_out, exp_r.read_only_out);
                        $display({"  actual   found=%0b slot=%0d vpn=%05h pid=%02h",
                                  " phys=%03h vdur=%b%b%b%b"},
                                 got.found, got.slot_out, got.vpn_out, got.pid_out,
                                 got.phys_page_out, got.valid_out, got.dirty_out,
                                 got.use_out, got.read_only_out);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no beat moves on either side for too long.
    // The limit covers the clearing pass, the long hold-off and a full scan.
    // ------------------------------------------------------------------
    initial begin
        wait (aresetn === 1'b1);
        while (stuck_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (ops_seen[i])
            ops_seen[i] = 0;
        foreach (shadow_map[i]) begin
            shadow_map[i] = 1'b0;
            shadow_ent[i] = '0;
        end
        last_grant    = 0;
        last_grant_ok = 1'b0;

        // pools carry both extremes plus a few random keys
        vpn_pool[0] = '0;
        vpn_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            vpn_pool[i] = sst_pkg::VPN_W'($urandom_range(0, (1 << sst_pkg::VPN_W) - 1));
        pid_pool[0] = '0;
        pid_pool[1] = '1;
        for (int i = 2; i < 4; i++)
            pid_pool[i] = sst_pkg::PID_W'($urandom_range(0, (1 << sst_pkg::PID_W) - 1));

        // Directed table. Answers are typed in only where they are plain
        // at a glance; the rest go through the predictor.
        add_row(cmd(sst_pkg::OP_READ, 0, 0, 0, 0, 4'h0), 1,
                result_of(0, 0, 0, 0, 0, 4'h0));
        add_row(cmd(sst_pkg::OP_READ, 63, 0, 0, 0, 4'h0), 1,
                result_of(0, 63, 0, 0, 0, 4'h0));
        add_row(cmd(sst_pkg::OP_SEARCH, 0, 0, 0, 0, 4'h0), 1, '0);  // nothing allocated yet
        add_row(cmd(sst_pkg::OP_ALLOC, 0, 0, 0, 0, 4'h0), 1,
                result_of(1, 0, 0, 0, 0, 4'h0));
        add_row(cmd(sst_pkg::OP_ALLOC, 0, 0, 0, 0, 4'h0), 1,
                result_of(1, 1, 0, 0, 0, 4'h0));
        add_row(cmd(sst_pkg::OP_WRITE, 0, 'hFFFFF, 'hFF, 'hFFF, 4'hF), 1, '0);
        add_row(cmd(sst_pkg::OP_READ, 0, 0, 0, 0, 4'h0), 1,
                result_of(0, 0, 'hFFFFF, 'hFF, 'hFFF, 4'hF));
        add_row(cmd(sst_pkg::OP_SEARCH, 0, 'hFFFFF, 'hFF, 0, 4'h0), 1,
                result_of(1, 0, 0, 0, 0, 4'h0));
        add_row(cmd(sst_pkg::OP_WRITE, 63, 0, 0, 0, 4'h0), 1, '0);
        add_row(cmd(sst_pkg::OP_WRITE, 1, 'h12345, 'h5A, 'hA5C, 4'b0101), 1, '0);
        add_row(cmd(sst_pkg::OP_READ, 1, 0, 0, 0, 4'h0), 0, '0);
        add_row(cmd(sst_pkg::OP_SEARCH, 0, 'h12345, 'h5A, 0, 4'h0), 0, '0);
        add_row(cmd(sst_pkg::OP_SEARCH, 0, 'h12345, 'h5B, 0, 4'h0), 0, '0);  // pid differs
        add_row(cmd(sst_pkg::OP_FREE_SLOT, 0, 0, 0, 0, 4'h0), 1, '0);
        // freed slot is skipped
        add_row(cmd(sst_pkg::OP_SEARCH, 0, 'hFFFFF, 'hFF, 0, 4'h0), 1, '0);
        add_row(cmd(sst_pkg::OP_ALLOC, 0, 0, 0, 0, 4'h0), 1,
                result_of(1, 0, 0, 0, 0, 4'h0));
        add_row(cmd(OP_UNUSED6, 63, 'hFFFFF, 'hFF, 'hFFF, 4'hF), 1, '0);
        add_row(cmd(OP_UNUSED7, 63, 'hFFFFF, 'hFF, 'hFFF, 4'hF), 1, '0);
        add_row(cmd(sst_pkg::OP_FREE_PID, 0, 0, 'h5A, 0, 4'h0), 1, '0);
        // released by pid
        add_row(cmd(sst_pkg::OP_SEARCH, 0, 'h12345, 'h5A, 0, 4'h0), 1, '0);
        add_row(cmd(sst_pkg::OP_READ, 1, 0, 0, 0, 4'h0), 0, '0);      // contents survive
        add_row(cmd(sst_pkg::OP_ALLOC, 0, 0, 0, 0, 4'h0), 0, '0);
        add_row(cmd(sst_pkg::OP_FREE_PID, 0, 0, 0, 0, 4'h0), 1, '0);  // hits free slots too
        add_row(cmd(sst_pkg::OP_ALLOC, 0, 0, 0, 0, 4'h0), 0, '0);
        add_row(cmd(sst_pkg::OP_READ, 63, 0, 0, 0, 4'h0), 0, '0);

        // Hold reset, then release it on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_steps[i])
            offer(directed_steps[i].beat, directed_steps[i].fixed, directed_steps[i].want);
        drain_results();

        // Fill the table and keep asking, so allocations get refused
        tx_busy = 1'b0;
        for (int i = 0; i < N_SLOTS + 4; i++) begin
            sst_pkg::req_t c;
            c    = make_cmd();
            c.op = sst_pkg::OP_ALLOC;
            offer(c, 1'b0, '0);
        end
        drain_results();

        // Random blocks: mostly slot lifetimes, the rest loose commands.
        // The sender pauses after each block until all results are in.
        for (int b = 0; b < N_BLOCKS; b++) begin
            int start;
            start   = cmds_sent;
            tx_busy = ($urandom_range(0, 2) != 0);
            while (cmds_sent - start < BLOCK_CMDS) begin
                if ($urandom_range(0, 9) < 4)
                    run_lifecycle();
                else
                    offer(make_cmd(), 1'b0, '0);
            end
            drain_results();
        end

        // Let any stray beat show itself before closing
        repeat (20) @(posedge aclk);

        $display({"Covered %0d commands: alloc %0d, search %0d, free slot %0d,",
                  " free pid %0d, write %0d, read %0d, unused %0d"},
                 cmds_sent, ops_seen[sst_pkg::OP_ALLOC], ops_seen[sst_pkg::OP_SEARCH],
                 ops_seen[sst_pkg::OP_FREE_SLOT], ops_seen[sst_pkg::OP_FREE_PID],
                 ops_seen[sst_pkg::OP_WRITE], ops_seen[sst_pkg::OP_READ],
                 ops_seen[OP_UNUSED6] + ops_seen[OP_UNUSED7]);
        $display("Checked %0d result beats: %0d refused allocations, %0d search hits, %0d errors",
                 beats_taken, full_refusals, search_hits, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/sst_pkg.sv
hdl/sst_ram.sv
hdl/sst_ctrl.sv
hdl/sst_dp.sv
hdl/swap_slot_table.sv
dv/tb_swap_slot_table.sv
